// ===== rtl/cfrp_pkg.sv =====
// Shared types and constants for the CAN feedback reassembly parser.
package cfrp_pkg;

    localparam int ID_W       = 29;
    localparam int DATA_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_SLOTS  = 3;
    localparam int REC_BYTES  = 24;
    localparam int BCC_SPAN   = 22;

    localparam logic [LEN_W-1:0] FRAME_LEN = 4'd8;
    localparam logic [7:0]       REC_HEAD  = 8'h7B;
    localparam logic [7:0]       REC_TAIL  = 8'h7D;

    typedef enum logic {
        ACT_FRAME = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_BCC   = 2'd1,
        STATUS_FRAME = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_ID  = 2'd0,
        CFG_SECOND_ID = 2'd1,
        CFG_THIRD_ID  = 2'd2
    } t_cfg_idx;

endpackage

// ===== rtl/can_feedback_reassembly_parser.sv =====
// Top level: reassembles three CAN frames into a feedback record and parses it.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one word per CAN frame or
//   clear action. A word is taken at a rising edge with i_in_valid high and
//   o_in_stall low. Frames with a length other than 8 or an identifier that
//   matches none of the three configured identifiers are dropped.
//   Output channel (o_out_valid / i_out_stall) carries one parsed record each
//   time the last missing one of the three slots is filled; the word is taken at an edge
//   with o_out_valid high and i_out_stall low.
//   Configuration: i_cfg_we writes i_cfg_wdata into identifier register
//   i_cfg_idx (0 first, 1 second, 2 third); index 3 is ignored. Write only
//   while the block is idle.
// Pipeline and throughput:
//   A word sits in the input register, then the slot update, the
//   header/tail check and the 22-byte XOR check run combinationally into the
//   output register: o_out_valid rises at the edge that moves the completing
//   frame out of the input register.
//   One word is taken every cycle while the output side keeps up.
// Reset: synchronous, active low; clears the received marks, both valid
//   flags and restores the identifiers to 1, 2 and 3.
// Stall: while a result waits, one more word is held in the input register;
//   o_in_stall rises only when both registers are full and the receiver stalls.
module can_feedback_reassembly_parser
    import cfrp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ID_W-1:0]       i_cfg_wdata,
    // input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_action,
    input  logic [ID_W-1:0]       i_frame_id,
    input  logic [LEN_W-1:0]      i_frame_length,
    input  logic [DATA_W-1:0]     i_frame_data,
    // output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic                  o_motor_halt,
    output logic signed [15:0]    o_vel_x,
    output logic signed [15:0]    o_vel_y,
    output logic signed [15:0]    o_vel_z,
    output logic signed [15:0]    o_accel_x,
    output logic signed [15:0]    o_accel_y,
    output logic signed [15:0]    o_accel_z,
    output logic signed [15:0]    o_rate_x,
    output logic signed [15:0]    o_rate_y,
    output logic signed [15:0]    o_rate_z,
    output logic [15:0]           o_battery_mv
);

    // identifier registers
    logic [ID_W-1:0] r_id [NUM_SLOTS];

    // input register
    logic              r_s1_vld;
    logic              r_s1_action;
    logic [ID_W-1:0]   r_s1_id;
    logic [LEN_W-1:0]  r_s1_len;
    logic [DATA_W-1:0] r_s1_data;

    // record slots and marks
    logic [DATA_W-1:0]    r_slot [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_rcvd;
    logic [NUM_SLOTS-1:0] n_rcvd;

    // output register
    logic                 r_out_vld;
    logic [1:0]           r_status;
    logic                 r_motor;
    logic [15:0]          r_word [10];
    logic [1:0]           n_status;
    logic                 n_motor;
    logic [15:0]          n_word [10];

    logic                 out_free;
    logic                 consume;
    logic                 s1_load;
    logic                 frame_ok;
    logic                 hit_any;
    logic [NUM_SLOTS-1:0] hit;
    logic                 rec_done;
    logic [DATA_W-1:0]    merged [NUM_SLOTS];
    logic [7:0]           rec_b [REC_BYTES];
    logic [7:0]           bcc;

    // Output register frees up when empty or when its word leaves this edge.
    assign out_free   = !r_out_vld || !i_out_stall;
    assign consume    = r_s1_vld && out_free;
    assign s1_load    = !r_s1_vld || consume;
    assign o_in_stall = !s1_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id[0] <= ID_W'(1);
            r_id[1] <= ID_W'(2);
            r_id[2] <= ID_W'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FIRST_ID:  r_id[0] <= i_cfg_wdata;
                CFG_SECOND_ID: r_id[1] <= i_cfg_wdata;
                CFG_THIRD_ID:  r_id[2] <= i_cfg_wdata;
                default: ; // no register at this index
            endcase
        end
    end

    // Input register: take a word whenever the slot is free or drains now.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_load) begin
            r_s1_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load && i_in_valid) begin
            r_s1_action <= i_action;
            r_s1_id     <= i_frame_id;
            r_s1_len    <= i_frame_length;
            r_s1_data   <= i_frame_data;
        end
    end

    // Slot match: first register in list order wins on duplicate identifiers.
    always_comb begin
        hit = '0;
        priority if (r_s1_id == r_id[0]) begin
            hit[0] = 1'b1;
        end else if (r_s1_id == r_id[1]) begin
            hit[1] = 1'b1;
        end else if (r_s1_id == r_id[2]) begin
            hit[2] = 1'b1;
        end else begin
            hit = '0;
        end
    end

    assign frame_ok = (r_s1_action == ACT_FRAME) && (r_s1_len == FRAME_LEN);
    assign hit_any  = frame_ok && (hit != '0);
    assign rec_done = hit_any && ((r_rcvd | hit) == '1);

    // Record view with the incoming frame already in its slot.
    always_comb begin
        for (int k = 0; k < NUM_SLOTS; k++) begin
            merged[k] = hit[k] ? r_s1_data : r_slot[k];
        end
        for (int i = 0; i < REC_BYTES; i++) begin
            rec_b[i] = merged[i / 8][(7 - (i % 8)) * 8 +: 8];
        end
        bcc = '0;
        for (int i = 0; i < BCC_SPAN; i++) begin
            bcc = bcc ^ rec_b[i];
        end
    end

    // Parse: header/tail checked before the checksum; fields zero on error.
    always_comb begin
        n_status = STATUS_OK;
        n_motor  = 1'b0;
        for (int k = 0; k < 10; k++) begin
            n_word[k] = '0;
        end
        priority if (rec_b[0] != REC_HEAD || rec_b[REC_BYTES-1] != REC_TAIL) begin
            n_status = STATUS_FRAME;
        end else if (bcc != rec_b[BCC_SPAN]) begin
            n_status = STATUS_BCC;
        end else begin
            n_motor = (rec_b[1] != 8'd0);
            for (int k = 0; k < 10; k++) begin
                n_word[k] = {rec_b[2 + 2 * k], rec_b[3 + 2 * k]};
            end
        end
    end

    // Marks: clear on the clear action or on record completion, else set on a matched frame.
    always_comb begin
        n_rcvd = r_rcvd;
        if (r_s1_action == ACT_CLEAR) begin
            n_rcvd = '0;
        end else if (rec_done) begin
            n_rcvd = '0;
        end else if (hit_any) begin
            n_rcvd = r_rcvd | hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rcvd <= '0;
        end else if (consume) begin
            r_rcvd <= n_rcvd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && hit_any) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                if (hit[k]) begin
                    r_slot[k] <= r_s1_data;
                end
            end
        end
    end

    // Output register: load a finished record, drop the flag once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (consume && rec_done) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && rec_done) begin
            r_status <= n_status;
            r_motor  <= n_motor;
            r_word   <= n_word;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_status        = r_status;
    assign o_motor_halt    = r_motor;
    assign o_vel_x         = r_word[0];
    assign o_vel_y         = r_word[1];
    assign o_vel_z         = r_word[2];
    assign o_accel_x       = r_word[3];
    assign o_accel_y       = r_word[4];
    assign o_accel_z       = r_word[5];
    assign o_rate_x        = r_word[6];
    assign o_rate_y        = r_word[7];
    assign o_rate_z        = r_word[8];
    assign o_battery_mv    = r_word[9];

endmodule

// ===== rtl/cfrp_checker.sv =====
// Port-level checker for the CAN feedback reassembly parser, with its bind.
module cfrp_checker
    import cfrp_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [1:0]         o_status,
    input logic               o_motor_halt,
    input logic signed [15:0] o_vel_x,
    input logic [15:0]        o_battery_mv
);

    // Stalled output word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_vel_x) && $stable(o_battery_mv))
        else $error("stalled output word changed");

    // Input side stalls only behind a waiting, stalled result.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == STATUS_OK || o_status == STATUS_BCC
            || o_status == STATUS_FRAME))
        else $error("undefined status code");

    // Failed records carry zero fields.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STATUS_OK |->
            !o_motor_halt && o_vel_x == 16'sd0 && o_battery_mv == 16'd0)
        else $error("failed record carries nonzero fields");

    // Reset empties the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind can_feedback_reassembly_parser cfrp_checker u_cfrp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_status        (o_status),
    .o_motor_halt    (o_motor_halt),
    .o_vel_x         (o_vel_x),
    .o_battery_mv    (o_battery_mv)
);
